// ----- hw/rtl/tcce_pkg.sv -----
package tcce_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int MEMORY_CELLS = 16384;

  localparam int CELL_W = 14;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [CELL_W-1:0] LINE_CELLS   = CELL_W'(COLUMNS);
  localparam logic [CELL_W-1:0] SCREEN_CELLS = CELL_W'(ROWS * COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [CELL_W:0]   ROOM_LIMIT   = (CELL_W + 1)'(MEMORY_CELLS);

  localparam logic [7:0]  TEXT_ATTRIBUTE_RESET = 8'd7;
  localparam logic [15:0] BLANK_CELL_RESET     = 16'd1824;

  // register index codes
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;
  localparam logic REG_BLANK_CELL     = 1'b1;

  // operation codes
  localparam logic OPER_CHAR  = 1'b0;
  localparam logic OPER_CLEAR = 1'b1;

  // control characters
  localparam logic [7:0] CHR_NUL = 8'd0;
  localparam logic [7:0] CHR_BS  = 8'd8;
  localparam logic [7:0] CHR_LF  = 8'd10;
  localparam logic [7:0] CHR_DEL = 8'd127;

  typedef enum logic [2:0] {
    MEM_NONE      = 3'd0,
    MEM_WRITE     = 3'd1,
    MEM_CLEAR_LINE = 3'd2,
    MEM_COPY_BASE = 3'd3,
    MEM_CLEAR_ALL = 3'd4
  } mem_op_t;

  typedef struct packed {
    mem_op_t           op;
    logic [CELL_W-1:0] addr;
    logic [15:0]       word;
    logic [CELL_W-1:0] start;
    logic [CELL_W-1:0] cursor;
    logic              update;
  } result_t;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } entry_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

endpackage

// ----- hw/rtl/tcce_front.sv -----
module tcce_front
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  character,
  input  logic        end_of_buffer,
  input  logic        queue_full,
  output logic        push,
  output entry_t      push_entry
);

  logic [7:0]        text_attribute;
  logic [15:0]       blank_cell;
  logic [CELL_W-1:0] screen_base, screen_base_next;
  logic [CELL_W-1:0] cursor_cell, cursor_cell_next;
  logic [COL_W-1:0]  column, column_next;
  logic [ROW_W-1:0]  row, row_next;
  logic              accept;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign push       = accept && (push_entry.count != 2'd0);

  always_comb begin
    logic [CELL_W-1:0] b, c, old_base, addr;
    logic [COL_W-1:0]  cl;
    logic [ROW_W-1:0]  r;
    logic [1:0]        cnt;
    logic              is_lf, is_print, wrap, mark;
    result_t [MAX_RESULTS-1:0] res;
    b        = screen_base;
    c        = cursor_cell;
    cl       = column;
    r        = row;
    cnt      = 2'd0;
    res      = '0;
    mark     = 1'b0;
    old_base = screen_base;
    addr     = cursor_cell;
    is_lf    = (operation == OPER_CHAR) && (character == CHR_LF);
    is_print = (operation == OPER_CHAR) && (character != CHR_NUL) && (character != CHR_DEL)
               && (character != CHR_BS) && (character != CHR_LF);
    wrap     = is_print && (column >= LAST_COL);

    if (operation == OPER_CLEAR) begin
      b   = '0;
      c   = '0;
      cl  = '0;
      r   = '0;
      res[0] = '{op: MEM_CLEAR_ALL, addr: '0, word: blank_cell, start: '0, cursor: '0,
                 update: 1'b1};
      cnt = 2'd1;
    end else if (character == CHR_BS) begin
      if (cl != '0) begin
        c  = c - CELL_W'(1);
        cl = cl - COL_W'(1);
        res[0] = '{op: MEM_WRITE, addr: c, word: blank_cell, start: b, cursor: c,
                   update: 1'b1};
        cnt = 2'd1;
      end
    end

    // wrap returns to column zero before the line advance
    if (wrap) begin
      c  = c - CELL_W'(cl);
      cl = '0;
    end

    if (is_lf || wrap) begin
      if (r < LAST_ROW) begin
        c = c + LINE_CELLS;
        r = r + ROW_W'(1);
      end else begin
        if (({1'b0, b} + (CELL_W + 1)'(SCREEN_CELLS) + (CELL_W + 1)'(LINE_CELLS))
            >= ROOM_LIMIT) begin
          // out of memory: relocate the screen to the base first
          old_base = b;
          c        = c - old_base;
          b        = '0;
          res[cnt] = '{op: MEM_COPY_BASE, addr: old_base, word: '0, start: b, cursor: c,
                       update: 1'b1};
          cnt      = cnt + 2'd1;
        end
        addr     = b + SCREEN_CELLS;
        b        = b + LINE_CELLS;
        c        = c + LINE_CELLS;
        res[cnt] = '{op: MEM_CLEAR_LINE, addr: addr, word: blank_cell, start: b, cursor: c,
                     update: 1'b1};
        cnt      = cnt + 2'd1;
      end
    end

    if (is_lf) begin
      c    = c - CELL_W'(cl);
      cl   = '0;
      mark = 1'b1;
    end

    if (is_print) begin
      addr     = c;
      c        = c + CELL_W'(1);
      cl       = cl + COL_W'(1);
      res[cnt] = '{op: MEM_WRITE, addr: addr, word: {text_attribute, character}, start: b,
                   cursor: c, update: 1'b0};
      cnt      = cnt + 2'd1;
    end

    if (end_of_buffer) mark = 1'b1;

    if (mark) begin
      if (cnt == 2'd0) begin
        res[0] = '{op: MEM_NONE, addr: '0, word: '0, start: b, cursor: c, update: 1'b1};
        cnt    = 2'd1;
      end else begin
        res[cnt - 2'd1].cursor = c;
        res[cnt - 2'd1].update = 1'b1;
      end
    end

    screen_base_next = b;
    cursor_cell_next = c;
    column_next      = cl;
    row_next         = r;
    push_entry.count = cnt;
    push_entry.res   = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_base    <= '0;
      cursor_cell    <= '0;
      column         <= '0;
      row            <= '0;
      text_attribute <= TEXT_ATTRIBUTE_RESET;
      blank_cell     <= BLANK_CELL_RESET;
    end else begin
      if (accept) begin
        screen_base <= screen_base_next;
        cursor_cell <= cursor_cell_next;
        column      <= column_next;
        row         <= row_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_TEXT_ATTRIBUTE: text_attribute <= cfg_data[7:0];
          REG_BLANK_CELL:     blank_cell     <= cfg_data;
          default:            ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/tcce_queue.sv -----
module tcce_queue
  import tcce_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output qhead_t head
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = (fill == QCNT_W'(QDEPTH));
  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hw/rtl/tcce_back.sv -----
module tcce_back
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  qhead_t      head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  mem_op,
  output logic [13:0] mem_addr,
  output logic [15:0] mem_word,
  output logic [13:0] screen_start,
  output logic [13:0] cursor_offset,
  output logic        cursor_update,
  output logic        last
);

  logic [1:0] idx;
  result_t    cur;
  logic       take;

  assign cur           = head.entry.res[idx];
  assign result_valid  = head.valid;
  assign take          = head.valid && !result_stall;
  assign last          = (idx == head.entry.count - 2'd1);
  assign pop           = take && last;
  assign mem_op        = cur.op;
  assign mem_addr      = cur.addr;
  assign mem_word      = cur.word;
  assign screen_start  = cur.start;
  assign cursor_offset = cur.cursor;
  assign cursor_update = cur.update;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ----- hw/rtl/text_console_cursor_engine.sv -----
// channel  valid         stall         payload
// item     item_valid    item_stall    operation, character, end_of_buffer
// result   result_valid  result_stall  mem_op, mem_addr, mem_word, screen_start,
//                                      cursor_offset, cursor_update, last
// config   cfg_write     -             cfg_index, cfg_data
//
// an item is taken every cycle while the two-entry queue has room; its 0 to 3
// result words are worked out in the same cycle and queued, a silent item queues none
// the back end sends one result word per cycle while result_stall is low, so relocations and wraps that
// scroll (2 or 3 words) hold the item side once the queue fills
// a result word can appear the cycle after its item is taken
// rst is synchronous: position state clears, registers return to defaults
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  character,
  input  logic        end_of_buffer,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  mem_op,
  output logic [13:0] mem_addr,
  output logic [15:0] mem_word,
  output logic [13:0] screen_start,
  output logic [13:0] cursor_offset,
  output logic        cursor_update,
  output logic        last
);

  logic   push, pop, queue_full;
  entry_t push_entry;
  qhead_t head;

  tcce_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .character     (character),
    .end_of_buffer (end_of_buffer),
    .queue_full    (queue_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  tcce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .mem_op        (mem_op),
    .mem_addr      (mem_addr),
    .mem_word      (mem_word),
    .screen_start  (screen_start),
    .cursor_offset (cursor_offset),
    .cursor_update (cursor_update),
    .last          (last)
  );

endmodule

// ----- tb/text_console_cursor_engine_tb.sv -----
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int PRESSURE_HOLD = 64;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    mem_op_t     op;
    logic [13:0] addr;
    logic [15:0] word;
    logic [13:0] start;
    logic [13:0] cursor;
    logic        update;
    logic        last;
  } console_action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_TEXT_ATTRIBUTE;
  logic [15:0] cfg_data = 16'h0000;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        operation = OPER_CHAR;
  logic [7:0]  character = CHR_NUL;
  logic        end_of_buffer = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  mem_op;
  logic [13:0] mem_addr;
  logic [15:0] mem_word;
  logic [13:0] screen_start;
  logic [13:0] cursor_offset;
  logic        cursor_update;
  logic        last;

  // predicted console state
  logic [7:0]  model_attr;
  logic [15:0] model_blank;
  logic [13:0] model_base;
  logic [13:0] model_cursor;
  logic [6:0]  model_column;
  logic [4:0]  model_row;

  console_action_t step_actions[$];
  console_action_t due_actions[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int roll;

  text_console_cursor_engine u_dut (.*);

  always #10 clk = ~clk;

  function automatic bit has_room();
    return (int'(model_base) + ROWS * COLUMNS + COLUMNS) < MEMORY_CELLS;
  endfunction

  function automatic logic [7:0] random_printable();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CHR_NUL || ch == CHR_BS || ch == CHR_LF || ch == CHR_DEL);
    return ch;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_action(input mem_op_t op, input logic [13:0] addr,
                            input logic [15:0] word, input logic update);
    step_actions.push_back('{op, addr, word, model_base, model_cursor, update, 1'b0});
  endtask

  task automatic scroll_line();
    logic [13:0] line;
    line = model_base + SCREEN_CELLS;
    model_base = model_base + LINE_CELLS;
    model_cursor = model_cursor + LINE_CELLS;
    add_action(MEM_CLEAR_LINE, line, model_blank, 1'b1);
  endtask

  task automatic next_line();
    logic [13:0] old_base;
    if (model_row < LAST_ROW) begin
      model_cursor = model_cursor + LINE_CELLS;
      model_row = model_row + 1'b1;
    end else begin
      // out of memory: screen goes back to the base, then the normal scroll
      if (!has_room()) begin
        old_base = model_base;
        model_cursor = model_cursor - old_base;
        model_base = '0;
        add_action(MEM_COPY_BASE, old_base, 16'h0000, 1'b1);
      end
      scroll_line();
    end
  endtask

  task automatic line_start();
    model_cursor = model_cursor - 14'(model_column);
    model_column = '0;
  endtask

  task automatic post_cursor();
    int n;
    n = step_actions.size();
    if (n == 0) begin
      add_action(MEM_NONE, 14'h0000, 16'h0000, 1'b1);
    end else begin
      step_actions[n-1].cursor = model_cursor;
      step_actions[n-1].update = 1'b1;
    end
  endtask

  task automatic predict_console_step(input logic op, input logic [7:0] ch,
                                      input logic eob);
    logic [13:0] write_addr;
    int n;
    step_actions.delete();
    if (op == OPER_CLEAR) begin
      model_base = '0;
      model_cursor = '0;
      model_column = '0;
      model_row = '0;
      add_action(MEM_CLEAR_ALL, 14'h0000, model_blank, 1'b1);
    end else if (ch == CHR_NUL || ch == CHR_DEL) begin
      // ignored
    end else if (ch == CHR_BS) begin
      if (model_column != 0) begin
        model_cursor = model_cursor - 1'b1;
        model_column = model_column - 1'b1;
        add_action(MEM_WRITE, model_cursor, model_blank, 1'b1);
      end
    end else if (ch == CHR_LF) begin
      next_line();
      line_start();
      post_cursor();
    end else begin
      if (model_column >= LAST_COL) begin
        line_start();
        next_line();
      end
      write_addr = model_cursor;
      model_cursor = model_cursor + 1'b1;
      model_column = model_column + 1'b1;
      add_action(MEM_WRITE, write_addr, {model_attr, ch}, 1'b0);
    end
    if (eob) post_cursor();
    n = step_actions.size();
    if (n != 0) step_actions[n-1].last = 1'b1;
    foreach (step_actions[i]) due_actions.push_back(step_actions[i]);
  endtask

  task automatic send_char(input logic op, input logic [7:0] ch, input logic eob);
    int gap;
    bit taken;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    character <= ch;
    end_of_buffer <= eob;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    predict_console_step(op, ch, eob);
  endtask

  task automatic send_random_char();
    int r;
    logic op;
    logic [7:0] ch;
    logic eob;
    r = $urandom_range(0, 99);
    op = OPER_CHAR;
    ch = 8'($urandom_range(0, 255));
    if (r < 3) op = OPER_CLEAR;
    else if (r < 13) ch = CHR_LF;
    else if (r < 21) ch = CHR_BS;
    else if (r < 25) ch = CHR_NUL;
    else if (r < 28) ch = CHR_DEL;
    eob = ($urandom_range(0, 6) == 0);
    send_char(op, ch, eob);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [7:0] attr, input logic [15:0] blank);
    cfg_write <= 1'b1;
    cfg_index <= REG_TEXT_ATTRIBUTE;
    cfg_data <= {8'h00, attr};
    @(posedge clk);
    cfg_index <= REG_BLANK_CELL;
    cfg_data <= blank;
    @(posedge clk);
    cfg_write <= 1'b0;
    model_attr = attr;
    model_blank = blank;
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_char(OPER_CHAR, CHR_BS, 1'b0);
    send_char(OPER_CHAR, CHR_NUL, 1'b0);
    send_char(OPER_CHAR, CHR_DEL, 1'b0);
    send_char(OPER_CHAR, CHR_NUL, 1'b1);
    send_char(OPER_CHAR, CHR_DEL, 1'b1);
    send_char(OPER_CHAR, 8'h41, 1'b0);
    send_char(OPER_CHAR, 8'hFF, 1'b0);
    send_char(OPER_CHAR, 8'h01, 1'b0);
    send_char(OPER_CHAR, 8'h80, 1'b1);
    send_char(OPER_CHAR, 8'h7E, 1'b0);
    send_char(OPER_CHAR, CHR_BS, 1'b0);
    send_char(OPER_CHAR, CHR_BS, 1'b1);
    send_char(OPER_CHAR, CHR_LF, 1'b0);
    send_char(OPER_CHAR, CHR_LF, 1'b1);
    send_char(OPER_CHAR, 8'h09, 1'b0);
    send_char(OPER_CHAR, 8'h1B, 1'b0);
    send_char(OPER_CLEAR, 8'h55, 1'b0);
    send_char(OPER_CHAR, 8'h20, 1'b0);
    send_char(OPER_CLEAR, CHR_NUL, 1'b1);
    wait_drained();
  endtask

  task automatic test_scroll_relocation();
    set_registers(8'h00, 16'h0000);
    send_char(OPER_CLEAR, 8'h00, 1'b0);
    // scroll down until the last row has no room left below the screen
    while (model_row != LAST_ROW || has_room())
      send_char(OPER_CHAR, CHR_LF, ($urandom_range(0, 7) == 0));
    wait_drained();
  endtask

  task automatic test_line_wrap();
    set_registers(8'hFF, 16'hFFFF);
    repeat (COLUMNS) send_char(OPER_CHAR, random_printable(), 1'b0);
    // backspace from the right edge, then fill it again
    send_char(OPER_CHAR, CHR_BS, 1'b0);
    send_char(OPER_CHAR, random_printable(), 1'b0);
    // wrap on the last row with no room left: copy, clear line, write
    send_char(OPER_CHAR, random_printable(), 1'b1);
    send_char(OPER_CHAR, CHR_BS, 1'b0);
    send_char(OPER_CHAR, CHR_BS, 1'b0);
    send_char(OPER_CHAR, CHR_LF, 1'b0);
    wait_drained();
  endtask

  task automatic test_input_backpressure();
    set_registers(8'h5A, 16'hA5C3);
    steady = 1'b1;
    hold_req++;
    repeat (24) begin
      if ($urandom_range(0, 2) == 0) send_char(OPER_CHAR, CHR_LF, 1'b1);
      else send_char(OPER_CHAR, random_printable(), 1'b0);
    end
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    set_registers(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    for (int i = 0; i < 45; i++) begin
      steady = (i < 15);
      send_random_char();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  // receiver side: random stalls, or one long hold when asked
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_left = PRESSURE_HOLD;
    end else if (stall_left == 0 && !steady) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) stall_left = $urandom_range(10, 30);
      else if (roll >= 70) stall_left = $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // sampled on the falling edge, the word is taken at the next rising edge
  always @(negedge clk) begin : check_results
    console_action_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_actions.size() == 0) begin
        $error("unexpected result word: mem_op %0d mem_addr %0h", mem_op, mem_addr);
        mismatch_count++;
      end else begin
        want = due_actions.pop_front();
        check_field("mem_op", 16'(want.op), 16'(mem_op));
        check_field("mem_addr", 16'(want.addr), 16'(mem_addr));
        check_field("mem_word", want.word, mem_word);
        check_field("screen_start", 16'(want.start), 16'(screen_start));
        check_field("cursor_offset", 16'(want.cursor), 16'(cursor_offset));
        check_field("cursor_update", 16'(want.update), 16'(cursor_update));
        check_field("last", 16'(want.last), 16'(last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    model_attr = TEXT_ATTRIBUTE_RESET;
    model_blank = BLANK_CELL_RESET;
    model_base = '0;
    model_cursor = '0;
    model_column = '0;
    model_row = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_scroll_relocation();
    test_line_wrap();
    test_input_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && due_actions.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_front.sv
hw/rtl/tcce_queue.sv
hw/rtl/tcce_back.sv
hw/rtl/text_console_cursor_engine.sv
tb/text_console_cursor_engine_tb.sv
